// ===== hdl/efv_pkg.sv =====
// Shared types, constants and tables for the elliptic flame variation datapath.
package efv_pkg;

  localparam int ONE_Q24 = 16777216;
  localparam int ONE_Q30 = 1073741824;
  localparam int CORDIC_STEPS = 30;
  localparam int LOG_TERMS = 12;
  localparam int SAT_W = 72;

  localparam logic signed [31:0] AMOUNT_RESET = 32'sd16777216;
  localparam logic signed [31:0] TWO_OVER_PI_Q30 = 32'sd683565276;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               negate_y;
  } efv_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } efv_out_t;

  typedef struct packed {
    logic               x_neg;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic               negate_y;
    logic signed [31:0] out_z;
  } efv_side_t;

  typedef struct packed {
    efv_side_t   side;
    logic [31:0] xmax;
    logic [31:0] ux;
  } efv_lsq_tag_t;

  typedef struct packed {
    efv_side_t   side;
    logic [32:0] w;
  } efv_wtag_t;

  typedef struct packed {
    efv_side_t   side;
    logic [32:0] w;
    logic [24:0] amag;
  } efv_btag_t;

  typedef struct packed {
    efv_side_t          side;
    logic signed [32:0] ang;
  } efv_atag_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021688;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      default: v = 30'(ONE_Q30 >> i);
    endcase
    return v;
  endfunction

  // Reciprocal of the odd divisor 2j+1, floored, in units of 2^-32.
  function automatic logic [31:0] recip_q32(input int j);
    logic [31:0] v;
    case (j)
      1:  v = 32'd1431655765;
      2:  v = 32'd858993459;
      3:  v = 32'd613566756;
      4:  v = 32'd477218588;
      5:  v = 32'd390451572;
      6:  v = 32'd330382099;
      7:  v = 32'd286331153;
      8:  v = 32'd252645135;
      9:  v = 32'd226050910;
      10: v = 32'd204522252;
      11: v = 32'd186737708;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
    lo = {{(SAT_W-31){1'b1}}, {31{1'b0}}};
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

endpackage

// ===== hdl/elliptic_flame_variation.sv =====
// Top level of the elliptic flame variation: front end, root, divide, CORDIC, log and scaling.
// Throughput: one item per clock; busy is never raised, since every unit is fully pipelined.
// The depth is set by the bit-serial root and divider stages and the 30 CORDIC steps.
// Reset clears all valid bits and restores amount to 1.0; the receiver cannot stall.
module elliptic_flame_variation
  import efv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  efv_in_t     point,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        done,
  output efv_out_t    result
);

  logic signed [31:0] amount;

  logic               p1_vld, p2_vld, p3_vld;
  efv_in_t            p1, p2;
  logic [32:0]        p2_up, p2_um;
  logic [31:0]        p2_uy, p2_ux;
  logic signed [63:0] p2_zp;
  logic [63:0]        p3_up2, p3_um2, p3_uy2;
  logic [31:0]        p3_ux;
  efv_side_t          p3_side;

  logic               sa_vld;
  logic [31:0]        s1, s2;
  efv_side_t          sa_tag;
  logic [31:0]        sb_tag;

  logic               x_vld;
  efv_lsq_tag_t       x_tag;
  logic [32:0]        x_sum;

  logic               l_vld;
  logic [27:0]        l_root;
  efv_lsq_tag_t       l_tag;
  logic [32:0]        l_w;

  logic               d_vld;
  logic [24:0]        d_q;
  logic               d_ovf;
  efv_wtag_t          d_tag;

  logic               a_vld;
  logic [49:0]        a_sq;
  efv_btag_t          a_tag;

  logic               b_vld;
  logic [24:0]        b_root;
  efv_btag_t          b_tag;

  logic               c_vld;
  logic signed [32:0] c_ang;
  efv_wtag_t          c_tag;

  logic               n_vld;
  logic [33:0]        n_lg;
  efv_atag_t          n_tag;

  logic               e1_vld, e2_vld, e3_vld;
  efv_side_t          e1_side, e2_side, e3_side;
  logic signed [63:0] e1_pa;
  logic signed [67:0] e1_pb;
  logic signed [33:0] e2_ua;
  logic signed [37:0] e2_ub;
  logic signed [65:0] e3_ta;
  logic signed [69:0] e3_tb;
  logic signed [35:0] tx;
  logic signed [39:0] ty;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      amount <= AMOUNT_RESET;
    end else if (cfg_we) begin
      amount <= signed'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      p1_vld <= start & ~busy;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
    p1 <= point;

    p2    <= p1;
    p2_up <= 33'(((34'(p1.in_x) + 34'(ONE_Q24)) < 0) ? -(34'(p1.in_x) + 34'(ONE_Q24))
                                                     : (34'(p1.in_x) + 34'(ONE_Q24)));
    p2_um <= 33'(((34'(p1.in_x) - 34'(ONE_Q24)) < 0) ? -(34'(p1.in_x) - 34'(ONE_Q24))
                                                     : (34'(p1.in_x) - 34'(ONE_Q24)));
    p2_uy <= 32'((p1.in_y < 0) ? -33'(p1.in_y) : 33'(p1.in_y));
    p2_ux <= 32'((p1.in_x < 0) ? -33'(p1.in_x) : 33'(p1.in_x));
    p2_zp <= 64'(amount) * 64'(p1.in_z);

    p3_up2 <= 64'(p2_up) * 64'(p2_up);
    p3_um2 <= 64'(p2_um) * 64'(p2_um);
    p3_uy2 <= 64'(p2_uy) * 64'(p2_uy);
    p3_ux  <= p2_ux;
    p3_side.x_neg    <= p2.in_x[31];
    p3_side.acc_x    <= p2.acc_x;
    p3_side.acc_y    <= p2.acc_y;
    p3_side.negate_y <= p2.negate_y;
    p3_side.out_z    <= sat32(SAT_W'(p2.acc_z) + SAT_W'((p2_zp + 64'sd8388608) >>> 24));
  end

  efv_isqrt #(.IN_W(64), .TAG_W($bits(efv_side_t))) u_sqrt_p (
    .clk(clk), .rst(rst), .in_valid(p3_vld), .rad(p3_up2 + p3_uy2), .in_tag(p3_side),
    .out_valid(sa_vld), .root(s1), .out_tag(sa_tag)
  );

  efv_isqrt #(.IN_W(64), .TAG_W(32)) u_sqrt_m (
    .clk(clk), .rst(rst), .in_valid(p3_vld), .rad(p3_um2 + p3_uy2), .in_tag(p3_ux),
    .out_valid(), .root(s2), .out_tag(sb_tag)
  );

  assign x_sum = 33'(s1) + 33'(s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else begin
      x_vld <= sa_vld;
    end
    x_tag.side <= sa_tag;
    x_tag.xmax <= (x_sum[32:1] == 32'd0) ? 32'd1 : x_sum[32:1];
    x_tag.ux   <= sb_tag;
  end

  efv_isqrt #(.IN_W(56), .TAG_W($bits(efv_lsq_tag_t))) u_sqrt_l (
    .clk(clk), .rst(rst), .in_valid(x_vld),
    .rad((x_tag.xmax > 32'(ONE_Q24)) ? {x_tag.xmax - 32'(ONE_Q24), 24'd0} : 56'd0),
    .in_tag(x_tag),
    .out_valid(l_vld), .root(l_root), .out_tag(l_tag)
  );

  assign l_w = ((33'(l_tag.xmax) + 33'(l_root)) < 33'(ONE_Q24)) ? 33'(ONE_Q24)
             : (33'(l_tag.xmax) + 33'(l_root));

  efv_div #(.N_W(56), .D_W(32), .Q_W(25), .TAG_W($bits(efv_wtag_t))) u_div_a (
    .clk(clk), .rst(rst), .in_valid(l_vld),
    .num({l_tag.ux, 24'd0}), .den(l_tag.xmax), .in_tag({l_tag.side, l_w}),
    .out_valid(d_vld), .quo(d_q), .ovf(d_ovf), .out_tag(d_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= d_vld;
    end
    a_tag.side <= d_tag.side;
    a_tag.w    <= d_tag.w;
    if (d_ovf || (d_q > 25'(ONE_Q24))) begin
      a_tag.amag <= 25'(ONE_Q24);
      a_sq       <= 50'(ONE_Q24) * 50'(ONE_Q24);
    end else begin
      a_tag.amag <= d_q;
      a_sq       <= 50'(d_q) * 50'(d_q);
    end
  end

  efv_isqrt #(.IN_W(50), .TAG_W($bits(efv_btag_t))) u_sqrt_b (
    .clk(clk), .rst(rst), .in_valid(a_vld), .rad((50'd1 << 48) - a_sq), .in_tag(a_tag),
    .out_valid(b_vld), .root(b_root), .out_tag(b_tag)
  );

  efv_cordic #(.TAG_W($bits(efv_wtag_t))) u_cordic (
    .clk(clk), .rst(rst), .in_valid(b_vld),
    .a(b_tag.side.x_neg ? -signed'(26'(b_tag.amag)) : signed'(26'(b_tag.amag))),
    .b(b_root), .in_tag({b_tag.side, b_tag.w}),
    .out_valid(c_vld), .ang(c_ang), .out_tag(c_tag)
  );

  efv_ln #(.TAG_W($bits(efv_atag_t))) u_ln (
    .clk(clk), .rst(rst), .in_valid(c_vld), .w(c_tag.w), .in_tag({c_tag.side, c_ang}),
    .out_valid(n_vld), .lg(n_lg), .out_tag(n_tag)
  );

  assign tx = 36'((e3_ta + 66'sd536870912) >>> 30);
  assign ty = 40'((e3_tb + 70'sd536870912) >>> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
      e2_vld <= 1'b0;
      e3_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      e1_vld <= n_vld;
      e2_vld <= e1_vld;
      e3_vld <= e2_vld;
      done   <= e3_vld;
    end
    e1_side <= n_tag.side;
    e1_pa   <= 64'(n_tag.ang) * 64'(TWO_OVER_PI_Q30);
    e1_pb   <= 68'(signed'({1'b0, n_lg})) * 68'(TWO_OVER_PI_Q30);

    e2_side <= e1_side;
    e2_ua   <= 34'((e1_pa + 64'sd536870912) >>> 30);
    e2_ub   <= 38'((e1_pb + 68'sd536870912) >>> 30);

    e3_side <= e2_side;
    e3_ta   <= 66'(amount) * 66'(e2_ua);
    e3_tb   <= 70'(amount) * 70'(e2_ub);

    result.out_x <= sat32(SAT_W'(e3_side.acc_x) + SAT_W'(tx));
    result.out_y <= e3_side.negate_y ? sat32(SAT_W'(e3_side.acc_y) - SAT_W'(ty))
                                     : sat32(SAT_W'(e3_side.acc_y) + SAT_W'(ty));
    result.out_z <= e3_side.out_z;
  end

endmodule

// ===== hdl/efv_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a tag carried alongside.
module efv_isqrt #(
  parameter int IN_W  = 64,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [IN_W-1:0]    rad,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_valid,
  output logic [IN_W/2-1:0]  root,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW = IN_W + 1;

  logic [OUT_W:0]   vld;
  logic [RW-1:0]    v   [0:OUT_W];
  logic [RW-1:0]    r   [0:OUT_W];
  logic [TAG_W-1:0] tg  [0:OUT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_W-1:0], in_valid};
    end
    v[0]  <= RW'(rad);
    r[0]  <= '0;
    tg[0] <= in_tag;
    for (int i = 0; i < OUT_W; i++) begin
      if (v[i] >= r[i] + (RW'(1) << (IN_W - 2 - 2 * i))) begin
        v[i+1] <= v[i] - (r[i] + (RW'(1) << (IN_W - 2 - 2 * i)));
        r[i+1] <= (r[i] >> 1) + (RW'(1) << (IN_W - 2 - 2 * i));
      end else begin
        v[i+1] <= v[i];
        r[i+1] <= r[i] >> 1;
      end
      tg[i+1] <= tg[i];
    end
  end

  assign out_valid = vld[OUT_W];
  assign root      = r[OUT_W][OUT_W-1:0];
  assign out_tag   = tg[OUT_W];

endmodule

// ===== hdl/efv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module efv_div #(
  parameter int N_W   = 56,
  parameter int D_W   = 32,
  parameter int Q_W   = 25,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [N_W-1:0]   num,
  input  logic [D_W-1:0]   den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo,
  output logic             ovf,
  output logic [TAG_W-1:0] out_tag
);

  localparam int RW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [Q_W:0]     vld;
  logic [Q_W:0]     of;
  logic [RW-1:0]    rem [0:Q_W];
  logic [D_W-1:0]   d   [0:Q_W];
  logic [Q_W-1:0]   q   [0:Q_W];
  logic [TAG_W-1:0] tg  [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Q_W-1:0], in_valid};
    end
    rem[0] <= RW'(num);
    d[0]   <= den;
    q[0]   <= '0;
    of[0]  <= ((RW + 1)'(num) >= ((RW + 1)'(den) << Q_W));
    tg[0]  <= in_tag;
    for (int i = 0; i < Q_W; i++) begin
      if (rem[i] >= (RW'(d[i]) << (Q_W - 1 - i))) begin
        rem[i+1] <= rem[i] - (RW'(d[i]) << (Q_W - 1 - i));
        q[i+1]   <= q[i] | (Q_W'(1) << (Q_W - 1 - i));
      end else begin
        rem[i+1] <= rem[i];
        q[i+1]   <= q[i];
      end
      d[i+1]  <= d[i];
      of[i+1] <= of[i];
      tg[i+1] <= tg[i];
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = q[Q_W];
  assign ovf       = of[Q_W];
  assign out_tag   = tg[Q_W];

endmodule

// ===== hdl/efv_cordic.sv =====
// Pipelined CORDIC in vectoring mode giving atan2(a, b) in Q30 radians.
module efv_cordic
  import efv_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [25:0] a,
  input  logic [24:0]        b,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_valid,
  output logic signed [32:0] ang,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int VW = 34;
  localparam int N = CORDIC_STEPS;

  logic [N:0]               vld;
  logic signed [VW-1:0]     xv [0:N];
  logic signed [VW-1:0]     yv [0:N];
  logic signed [32:0]       an [0:N];
  logic [TAG_W-1:0]         tg [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-1:0], in_valid};
    end
    xv[0] <= VW'({1'b0, b}) << 6;
    yv[0] <= VW'(a) <<< 6;
    an[0] <= '0;
    tg[0] <= in_tag;
    for (int i = 0; i < N; i++) begin
      if (yv[i] > 0) begin
        xv[i+1] <= xv[i] + (yv[i] >>> i);
        yv[i+1] <= yv[i] - (xv[i] >>> i);
        an[i+1] <= an[i] + signed'({3'b000, atan_q30(i)});
      end else begin
        xv[i+1] <= xv[i] - (yv[i] >>> i);
        yv[i+1] <= yv[i] + (xv[i] >>> i);
        an[i+1] <= an[i] - signed'({3'b000, atan_q30(i)});
      end
      tg[i+1] <= tg[i];
    end
  end

  assign out_valid = vld[N];
  assign ang       = an[N];
  assign out_tag   = tg[N];

endmodule

// ===== hdl/efv_ln.sv =====
// Pipelined natural logarithm: normalisation, series ratio division and an odd power series.
module efv_ln
  import efv_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [32:0]      w,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [33:0]      lg,
  output logic [TAG_W-1:0] out_tag
);

  localparam int L = LOG_TERMS;
  localparam int KT_W = TAG_W + 4;

  logic             v0, v1;
  logic [32:0]      w0;
  logic [TAG_W-1:0] t0, t1;
  logic [3:0]       k_c, k1;
  logic [30:0]      m1;

  logic             dv;
  logic [29:0]      s_d;
  logic [KT_W-1:0]  dt;

  logic [L:0]       vb;
  logic [L-1:0]     va;
  logic [29:0]      pb   [0:L];
  logic [29:0]      s2b  [0:L];
  logic [30:0]      sumb [0:L];
  logic [KT_W-1:0]  tb   [0:L];
  logic [29:0]      pa   [0:L-1];
  logic [59:0]      prod [0:L-1];
  logic [61:0]      pr   [0:L-1];
  logic [29:0]      s2a  [0:L-1];
  logic [30:0]      suma [0:L-1];
  logic [KT_W-1:0]  ta   [0:L-1];
  logic [29:0]      qt   [0:L-1];
  logic [29:0]      q0;
  logic [35:0]      rr;

  logic             vf;
  logic [33:0]      lg_r;
  logic [TAG_W-1:0] tf;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < 8; i++) begin
      if ((w0 >> (25 + i)) != 33'd0) k_c = 4'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
    end
    w0 <= w;
    t0 <= in_tag;
    k1 <= k_c;
    m1 <= 31'(({6'b0, w0} << 6) >> k_c);
    t1 <= t0;
  end

  efv_div #(
    .N_W(60), .D_W(32), .Q_W(30), .TAG_W(KT_W)
  ) u_div (
    .clk(clk), .rst(rst), .in_valid(v1),
    .num({m1[29:0], 30'd0}),
    .den(32'(m1) + 32'(ONE_Q30)),
    .in_tag({k1, t1}),
    .out_valid(dv), .quo(s_d), .ovf(), .out_tag(dt)
  );

  always_comb begin
    q0 = '0;
    rr = '0;
    for (int j = 0; j < L; j++) begin
      if (j == 0) begin
        qt[j] = pa[j];
      end else begin
        q0 = pr[j][61:32];
        rr = 36'(pa[j]) - 36'(q0) * 36'(2 * j + 1);
        qt[j] = (rr >= 36'(2 * j + 1)) ? q0 + 30'd1 : q0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
      va <= '0;
      vf <= 1'b0;
    end else begin
      vb <= {va, dv};
      va <= vb[L-1:0];
      vf <= vb[L];
    end
    pb[0]   <= s_d;
    s2b[0]  <= 30'((60'(s_d) * 60'(s_d)) >> 30);
    sumb[0] <= '0;
    tb[0]   <= dt;
    for (int j = 0; j < L; j++) begin
      pa[j]   <= pb[j];
      prod[j] <= 60'(pb[j]) * 60'(s2b[j]);
      pr[j]   <= 62'(pb[j]) * 62'(recip_q32(j));
      s2a[j]  <= s2b[j];
      suma[j] <= sumb[j];
      ta[j]   <= tb[j];
      pb[j+1]   <= prod[j][59:30];
      s2b[j+1]  <= s2a[j];
      sumb[j+1] <= suma[j] + 31'(qt[j]);
      tb[j+1]   <= ta[j];
    end
    lg_r <= 34'(tb[L][KT_W-1:TAG_W]) * 34'(LN2_Q30) + 34'({sumb[L], 1'b0});
    tf   <= tb[L][TAG_W-1:0];
  end

  assign out_valid = vf;
  assign lg        = lg_r;
  assign out_tag   = tf;

endmodule
